// File: sv/sprite_blit_braille_framebuffer_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the braille framebuffer unit
// Immediate-implication and next-cycle-implication checks, off in synthesis.
// ----------------------------------------------------------------------------
`ifndef SPRITE_BLIT_BRAILLE_FRAMEBUFFER_UNIT_MACROS_SVH
`define SPRITE_BLIT_BRAILLE_FRAMEBUFFER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SBBF_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define SBBF_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define SBBF_ASSERT_IMPLY(label, clk, rst, a, b)
`define SBBF_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// File: sv/sbbf_pkg.sv
// ----------------------------------------------------------------------------
// sbbf_pkg
// Types and constants shared by the braille framebuffer unit.
// ----------------------------------------------------------------------------
`default_nettype none
package sbbf_pkg;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_BLIT   = 2'd1;
  localparam logic [1:0] OP_RENDER = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam int FRAME_WIDTH_MAX  = 128;
  localparam int FRAME_HEIGHT_MAX = 64;
  localparam int SPRITE_SIDE_MAX  = 32;

  localparam logic [7:0] UTF8_LEAD = 8'hE2;
  localparam logic [7:0] UTF8_MID  = 8'hA0;
  localparam logic [7:0] UTF8_LAST = 8'h80;

  // Dot bit for each pixel of a cell: left column rows 0..3, then right column
  localparam logic [7:0] DOT_BIT [8] = '{8'h01, 8'h02, 8'h04, 8'h40,
                                         8'h08, 8'h10, 8'h20, 8'h80};

  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] pos_x;
    logic [5:0] pos_y;
    logic [7:0] pixel_value;
    logic [4:0] offset_x;
    logic [4:0] offset_y;
    logic [7:0] render_width;
    logic [6:0] render_height;
    logic [5:0] sprite_width;
    logic [5:0] sprite_height;
  } in_t;

  typedef struct packed {
    logic [7:0] utf8_lead;
    logic [7:0] utf8_mid;
    logic [7:0] utf8_last;
    logic       end_of_row;
  } out_t;

  typedef struct packed {
    logic capture;
    logic mod_step;
    logic row_next;
    logic px_clear;
    logic px_read;
    logic px_write;
    logic cell_read;
    logic cell_emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] in_op;
    logic       in_blit_nop;
    logic       in_render_ok;
    logic       mod_busy;
    logic       x_in;
    logic       y_in;
    logic       k_done;
    logic       row_last;
    logic       out_free;
  } status_t;

endpackage
`default_nettype wire

// File: sv/sbbf_ctrl.sv
// ----------------------------------------------------------------------------
// sbbf_ctrl
// Sequencer for load, blit, clear, render and the clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none
module sbbf_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire sbbf_pkg::status_t st,
  output sbbf_pkg::cmd_t       cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_BWR  = 3'd3;
  localparam logic [2:0] S_RRD  = 3'd4;
  localparam logic [2:0] S_ROUT = 3'd5;

  logic [2:0] state, state_next;
  logic       blit_mode, blit_mode_next;

  // State register; reset starts the clearing pass over the whole frame
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_WALK;
      blit_mode <= 1'b0;
    end else begin
      state     <= state_next;
      blit_mode <= blit_mode_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next     = state;
    blit_mode_next = blit_mode;
    cmd            = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (st.in_op)
            sbbf_pkg::OP_BLIT: begin
              blit_mode_next = 1'b1;
              if (!st.in_blit_nop) state_next = S_MOD;
            end
            sbbf_pkg::OP_RENDER: begin
              if (st.in_render_ok) state_next = S_RRD;
            end
            sbbf_pkg::OP_CLEAR: begin
              blit_mode_next = 1'b0;
              state_next     = S_WALK;
            end
            default: ;
          endcase
        end
      end
      S_MOD: begin
        if (st.mod_busy) cmd.mod_step = 1'b1;
        else state_next = S_WALK;
      end
      S_WALK: begin
        if (!st.y_in) begin
          state_next = S_IDLE;
        end else if (!st.x_in) begin
          cmd.row_next = 1'b1;
        end else if (blit_mode) begin
          cmd.px_read = 1'b1;
          state_next  = S_BWR;
        end else begin
          cmd.px_clear = 1'b1;
        end
      end
      S_BWR: begin
        cmd.px_write = 1'b1;
        state_next   = S_WALK;
      end
      S_RRD: begin
        cmd.cell_read = 1'b1;
        if (st.k_done) state_next = S_ROUT;
      end
      S_ROUT: begin
        if (st.out_free) begin
          cmd.cell_emit = 1'b1;
          state_next    = st.row_last ? S_IDLE : S_RRD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/sbbf_dp.sv
// ----------------------------------------------------------------------------
// sbbf_dp
// Frame and sprite memories, walk counters, cell assembly and output register.
// ----------------------------------------------------------------------------
`default_nettype none
module sbbf_dp (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sbbf_pkg::in_t   in_data,
  input  wire logic            cfg_we,
  input  wire logic            cfg_index,
  input  wire logic [7:0]      cfg_data,
  input  wire logic            out_stall,
  output logic                 out_valid,
  output sbbf_pkg::out_t       out_data,
  input  wire sbbf_pkg::cmd_t  cmd,
  output sbbf_pkg::status_t    st
);

  logic [7:0] frame_store [8192];
  logic [7:0] sprite_store [1024];

  logic [7:0] frame_width;
  logic [6:0] frame_height;
  logic [7:0] eff_w;
  logic [6:0] eff_h;

  logic [8:0] fx;
  logic [7:0] fy;
  logic [6:0] fx0;
  logic [7:0] xcnt;
  logic [6:0] ycnt;
  logic [7:0] wl;
  logic [6:0] hl;
  logic [7:0] rwl;
  logic [6:0] rhl;
  logic [5:0] sw, sh;
  logic [5:0] sx0, sx, sy;
  logic [3:0] k;
  logic [7:0] idx;
  logic [7:0] fr_q, sp_q;
  logic [12:0] faddr;
  logic [7:0] rfy;
  logic [8:0] rfx;
  logic [5:0] in_sw, in_sh;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 8'd128;
      frame_height <= 7'd64;
    end else if (cfg_we) begin
      if (cfg_index == sbbf_pkg::REG_FRAME_WIDTH) frame_width <= cfg_data;
      else frame_height <= cfg_data[6:0];
    end
  end

  // Clip to the frame size, rounded down to whole cells
  always_comb begin
    eff_w = (frame_width > 8'(sbbf_pkg::FRAME_WIDTH_MAX)) ?
            8'(sbbf_pkg::FRAME_WIDTH_MAX) : frame_width;
    eff_w = {eff_w[7:1], 1'b0};
    eff_h = (frame_height > 7'(sbbf_pkg::FRAME_HEIGHT_MAX)) ?
            7'(sbbf_pkg::FRAME_HEIGHT_MAX) : frame_height;
    eff_h = {eff_h[6:2], 2'b00};
  end

  // Saturate sprite size
  assign in_sw = (in_data.sprite_width > 6'(sbbf_pkg::SPRITE_SIDE_MAX)) ?
                 6'(sbbf_pkg::SPRITE_SIDE_MAX) : in_data.sprite_width;
  assign in_sh = (in_data.sprite_height > 6'(sbbf_pkg::SPRITE_SIDE_MAX)) ?
                 6'(sbbf_pkg::SPRITE_SIDE_MAX) : in_data.sprite_height;

  // Walk counters
  always_ff @(posedge clk) begin
    if (rst) begin
      fx   <= '0;
      fy   <= '0;
      fx0  <= '0;
      xcnt <= '0;
      ycnt <= '0;
      wl   <= 8'(sbbf_pkg::FRAME_WIDTH_MAX);
      hl   <= 7'(sbbf_pkg::FRAME_HEIGHT_MAX);
      rwl  <= 8'hFF;
      rhl  <= 7'h7F;
    end else if (cmd.capture) begin
      xcnt <= '0;
      ycnt <= '0;
      wl   <= eff_w;
      hl   <= eff_h;
      sw   <= in_sw;
      sh   <= in_sh;
      sx0  <= {1'b0, in_data.offset_x};
      sx   <= {1'b0, in_data.offset_x};
      sy   <= {1'b0, in_data.offset_y};
      k    <= '0;
      idx  <= '0;
      if (in_data.operation == sbbf_pkg::OP_BLIT) begin
        fx  <= {2'b00, in_data.pos_x};
        fx0 <= in_data.pos_x;
        fy  <= {2'b00, in_data.pos_y};
        rwl <= in_data.render_width;
        rhl <= in_data.render_height;
      end else if (in_data.operation == sbbf_pkg::OP_RENDER) begin
        fx  <= '0;
        fx0 <= '0;
        fy  <= {in_data.pos_y, 2'b00};
        rwl <= 8'hFF;
        rhl <= 7'h7F;
      end else begin
        fx  <= '0;
        fx0 <= '0;
        fy  <= '0;
        rwl <= 8'hFF;
        rhl <= 7'h7F;
      end
    end else begin
      // Reduce the start offsets one subtraction a cycle
      if (cmd.mod_step) begin
        if (sx0 >= sw) begin
          sx0 <= sx0 - sw;
          sx  <= sx0 - sw;
        end else begin
          sx  <= sx0;
        end
        if (sy >= sh) sy <= sy - sh;
      end
      if (cmd.row_next) begin
        fx   <= {2'b00, fx0};
        xcnt <= '0;
        fy   <= fy + 8'd1;
        ycnt <= ycnt + 7'd1;
        sx   <= sx0;
        sy   <= (sy + 6'd1 == sh) ? 6'd0 : sy + 6'd1;
      end
      if (cmd.px_clear || cmd.px_write) begin
        fx   <= fx + 9'd1;
        xcnt <= xcnt + 8'd1;
        sx   <= (sx + 6'd1 == sw) ? 6'd0 : sx + 6'd1;
      end
      if (cmd.cell_read) begin
        k <= k + 4'd1;
        if (k != 4'd0 && fr_q != 8'd0) idx <= idx | sbbf_pkg::DOT_BIT[3'(k - 4'd1)];
      end
      if (cmd.cell_emit) begin
        fx  <= fx + 9'd2;
        k   <= '0;
        idx <= '0;
      end
    end
  end

  // Frame address: walk pixel, or pixel k of the current cell
  assign rfy = fy + {6'd0, k[1:0]};
  assign rfx = fx + {8'd0, k[2]};
  assign faddr = cmd.cell_read ? {rfy[5:0], rfx[6:0]} : {fy[5:0], fx[6:0]};

  // Frame memory: read-modify-write for blit, zero for clear, cell reads for render
  always_ff @(posedge clk) begin
    if (cmd.px_read || (cmd.cell_read && k < 4'd8)) fr_q <= frame_store[faddr];
    if (cmd.px_clear) frame_store[faddr] <= 8'd0;
    else if (cmd.px_write) frame_store[faddr] <= fr_q + sp_q;
  end

  // Sprite memory
  always_ff @(posedge clk) begin
    if (cmd.capture && in_data.operation == sbbf_pkg::OP_LOAD &&
        in_data.pos_x < 7'(sbbf_pkg::SPRITE_SIDE_MAX) &&
        in_data.pos_y < 6'(sbbf_pkg::SPRITE_SIDE_MAX))
      sprite_store[{in_data.pos_y[4:0], in_data.pos_x[4:0]}] <= in_data.pixel_value;
    if (cmd.px_read) sp_q <= sprite_store[{sy[4:0], sx[4:0]}];
  end

  // Output register; drop valid once the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.cell_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cell_emit) begin
      out_data.utf8_lead  <= sbbf_pkg::UTF8_LEAD;
      out_data.utf8_mid   <= sbbf_pkg::UTF8_MID | {6'd0, idx[7:6]};
      out_data.utf8_last  <= sbbf_pkg::UTF8_LAST | {2'd0, idx[5:0]};
      out_data.end_of_row <= st.row_last;
    end
  end

  // Status to the sequencer
  always_comb begin
    st.in_op        = in_data.operation;
    st.in_blit_nop  = (in_data.sprite_width == 6'd0) || (in_data.sprite_height == 6'd0);
    st.in_render_ok = ({in_data.pos_y, 2'b00} < {1'b0, eff_h}) && (eff_w != 8'd0);
    st.mod_busy     = (sx0 >= sw) || (sy >= sh);
    st.x_in         = (fx < {1'b0, wl}) && (xcnt < rwl);
    st.y_in         = (fy < {1'b0, hl}) && (ycnt < rhl);
    st.k_done       = (k == 4'd8);
    st.row_last     = ((fx + 9'd2) >= {1'b0, wl});
    st.out_free     = !out_valid || !out_stall;
  end

endmodule
`default_nettype wire

// File: sv/sprite_blit_braille_framebuffer_unit.sv
// ----------------------------------------------------------------------------
// sprite_blit_braille_framebuffer_unit
// 128x64 8-bit framebuffer with tiled sprite blit and braille cell rendering.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries one command transaction:
// load a sprite pixel, blit the sprite, clear the frame or render a cell row.
// Output channel out_valid/out_stall/out_data carries one braille cell per
// transaction as three UTF-8 bytes; end_of_row marks the last cell of a row.
// frame_width/frame_height are to be written over cfg_we/cfg_index/cfg_data
// only while idle; the block itself does not enforce this. One command is
// worked at a time; in_stall is high while it runs. Clear zeroes each frame
// pixel, with a row step per row. Blit first reduces the start offsets, then
// does a frame read and a write back per drawn pixel, plus a row step per row.
// Render does the eight frame reads of each cell, then hands the cell to the
// output register. The single-port frame memory keeps these steps apart.
// Reset starts a clearing pass over the whole 128x64 frame; no command is
// taken before it ends. While the receiver stalls, the output register holds
// its cell and rendering pauses before the next one.
`default_nettype none
`include "sprite_blit_braille_framebuffer_unit_macros.svh"
module sprite_blit_braille_framebuffer_unit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire sbbf_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output sbbf_pkg::out_t      out_data,
  input  wire logic           cfg_we,
  input  wire logic           cfg_index,
  input  wire logic [7:0]     cfg_data
);

  sbbf_pkg::cmd_t    cmd;
  sbbf_pkg::status_t st;

  // Sequencer
  sbbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Memories and datapath
  sbbf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

  // A stalled cell stays put
  `SBBF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `SBBF_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(out_data))
  // Clear always walks the frame
  `SBBF_ASSERT_NEXT(a_clear_busy, clk, rst,
    in_valid && !in_stall && in_data.operation == sbbf_pkg::OP_CLEAR, in_stall)
  // A new cell is only loaded while rendering, never with input taken
  `SBBF_ASSERT_IMPLY(a_emit_busy, clk, rst, cmd.cell_emit, in_stall)

endmodule
`default_nettype wire
